### rtl/core/bez_pkg.sv
// ----------------------------------------------------------------------------
// bez_pkg
// Shared types and fixed widths of the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package bez_pkg;

  localparam int STEP_BITS  = 17;
  localparam int INDEX_BITS = 16;
  localparam int PROD_BITS  = STEP_BITS + INDEX_BITS;

  localparam logic [STEP_BITS-1:0] STEP_RESET = 17'd655;

  localparam int PARAM_STAGES = 4;
  localparam int BLEND_STAGES = 3;
  localparam int NUM_STAGES   = PARAM_STAGES + BLEND_STAGES;

  typedef struct packed {
    logic [PARAM_STAGES-1:0] param;
    logic [BLEND_STAGES-1:0] blend;
  } bez_adv_t;

endpackage

`default_nettype wire

### rtl/core/bez_param_gen.sv
// ----------------------------------------------------------------------------
// bez_param_gen
// Four-stage pipeline: t from index and step, clamp to one, then the four
// Bernstein weights (1-t)^3, 3t(1-t)^2, 3t^2(1-t) and t^3.
// ----------------------------------------------------------------------------
`default_nettype none

module bez_param_gen
  import bez_pkg::*;
#(
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire bez_adv_t                 adv,
  input  wire logic [STEP_BITS-1:0]     step,
  input  wire logic [INDEX_BITS-1:0]    index,
  output logic      [3*T_FRAC_BITS:0]   w0,
  output logic      [3*T_FRAC_BITS:0]   w1,
  output logic      [3*T_FRAC_BITS:0]   w2,
  output logic      [3*T_FRAC_BITS:0]   w3,
  output logic                          clamped
);

  localparam int TB  = T_FRAC_BITS + 1;
  localparam int T3B = T_FRAC_BITS + 3;
  localparam int SB  = 2 * T_FRAC_BITS + 1;
  localparam int WB  = 3 * T_FRAC_BITS + 1;
  localparam logic [PROD_BITS-1:0] T_ONE = PROD_BITS'(1) << T_FRAC_BITS;

  logic [PROD_BITS-1:0] prod_nxt, prod_r;

  logic          clamp_nxt, clamp_s2_r;
  logic [TB-1:0] t_nxt, t_s2_r;
  logic [TB-1:0] u_nxt, u_s2_r;
  logic [T3B-1:0] t3_nxt, t3_s2_r;

  logic [2*TB-1:0]     tt_full, uu_full;
  logic [T3B+TB-1:0]   tu3_full;
  logic [SB-1:0]       t2_r, u2_r, tu3_r;
  logic [TB-1:0]       t_s3_r, u_s3_r;
  logic                clamp_s3_r;

  logic [SB+TB-1:0] w0_full, w1_full, w2_full, w3_full;
  logic [WB-1:0]    w0_r, w1_r, w2_r, w3_r;
  logic             clamp_s4_r;

  assign prod_nxt = PROD_BITS'(index) * PROD_BITS'(step);

  always_ff @(posedge clk) begin
    if (adv.param[0]) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    clamp_nxt = prod_r > T_ONE;
    t_nxt     = clamp_nxt ? TB'(T_ONE) : prod_r[TB-1:0];
    u_nxt     = TB'(T_ONE) - t_nxt;
    t3_nxt    = (T3B'(t_nxt) << 1) + T3B'(t_nxt);
  end

  always_ff @(posedge clk) begin
    if (adv.param[1]) begin
      clamp_s2_r <= clamp_nxt;
      t_s2_r     <= t_nxt;
      u_s2_r     <= u_nxt;
      t3_s2_r    <= t3_nxt;
    end
  end

  assign tt_full  = t_s2_r * t_s2_r;
  assign uu_full  = u_s2_r * u_s2_r;
  assign tu3_full = t3_s2_r * u_s2_r;

  always_ff @(posedge clk) begin
    if (adv.param[2]) begin
      t2_r       <= tt_full[SB-1:0];
      u2_r       <= uu_full[SB-1:0];
      tu3_r      <= tu3_full[SB-1:0];
      t_s3_r     <= t_s2_r;
      u_s3_r     <= u_s2_r;
      clamp_s3_r <= clamp_s2_r;
    end
  end

  assign w0_full = u2_r * u_s3_r;
  assign w1_full = tu3_r * u_s3_r;
  assign w2_full = tu3_r * t_s3_r;
  assign w3_full = t2_r * t_s3_r;

  always_ff @(posedge clk) begin
    if (adv.param[3]) begin
      w0_r       <= w0_full[WB-1:0];
      w1_r       <= w1_full[WB-1:0];
      w2_r       <= w2_full[WB-1:0];
      w3_r       <= w3_full[WB-1:0];
      clamp_s4_r <= clamp_s3_r;
    end
  end

  assign w0      = w0_r;
  assign w1      = w1_r;
  assign w2      = w2_r;
  assign w3      = w3_r;
  assign clamped = clamp_s4_r;

endmodule

`default_nettype wire

### rtl/core/bez_blend.sv
// ----------------------------------------------------------------------------
// bez_blend
// Three-stage weighted sum of four offset-binary coordinates, rounded to the
// nearest integer and returned in two's complement.
// ----------------------------------------------------------------------------
`default_nettype none

module bez_blend
  import bez_pkg::*;
#(
  parameter int COORD_BITS  = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire bez_adv_t                adv,
  input  wire logic [COORD_BITS-1:0]   a,
  input  wire logic [COORD_BITS-1:0]   b,
  input  wire logic [COORD_BITS-1:0]   c,
  input  wire logic [COORD_BITS-1:0]   d,
  input  wire logic [3*T_FRAC_BITS:0]  w0,
  input  wire logic [3*T_FRAC_BITS:0]  w1,
  input  wire logic [3*T_FRAC_BITS:0]  w2,
  input  wire logic [3*T_FRAC_BITS:0]  w3,
  output logic      [COORD_BITS-1:0]   point
);

  localparam int SHIFT = 3 * T_FRAC_BITS;
  localparam int WB    = SHIFT + 1;
  localparam int AB    = COORD_BITS + WB;
  localparam logic [AB-1:0]         HALF      = AB'(1) << (SHIFT - 1);
  localparam logic [COORD_BITS-1:0] SIGN_MASK = COORD_BITS'(1) << (COORD_BITS - 1);

  logic [AB-1:0] m0_nxt, m1_nxt, m2_nxt, m3_nxt;
  logic [AB-1:0] m0_r, m1_r, m2_r, m3_r;
  logic [AB-1:0] s01_r, s23_r;
  logic [AB-1:0] acc;
  logic [COORD_BITS-1:0] point_nxt, point_r;

  assign m0_nxt = AB'(a) * AB'(w0);
  assign m1_nxt = AB'(b) * AB'(w1);
  assign m2_nxt = AB'(c) * AB'(w2);
  assign m3_nxt = AB'(d) * AB'(w3);

  always_ff @(posedge clk) begin
    if (adv.blend[0]) begin
      m0_r <= m0_nxt;
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      m3_r <= m3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.blend[1]) begin
      s01_r <= m0_r + m1_r + HALF;
      s23_r <= m2_r + m3_r;
    end
  end

  assign acc       = s01_r + s23_r;
  assign point_nxt = acc[SHIFT +: COORD_BITS] ^ SIGN_MASK;

  always_ff @(posedge clk) begin
    if (adv.blend[2]) begin
      point_r <= point_nxt;
    end
  end

  assign point = point_r;

endmodule

`default_nettype wire

### rtl/core/cubic_bezier_point_eval_unit.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_unit
// Cubic Bezier point evaluator: t = index * step clamped to one, Bernstein
// weights, exact weighted sum and round to nearest for x and y.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle without output stall, set by the seven-stage
// multiplier pipeline; an accepted word passes all stages to its result word.
// Bubbles close up under output stall, so input is taken while results wait.
// Reset: synchronous, active low; clears all stage valid bits and loads the
// step register with its default of 655.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_eval_unit
  import bez_pkg::*;
#(
  parameter int COORD_BITS  = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic        [STEP_BITS-1:0]   cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_BITS-1:0]  in_p0_x,
  input  wire logic signed [COORD_BITS-1:0]  in_p0_y,
  input  wire logic signed [COORD_BITS-1:0]  in_p1_x,
  input  wire logic signed [COORD_BITS-1:0]  in_p1_y,
  input  wire logic signed [COORD_BITS-1:0]  in_p2_x,
  input  wire logic signed [COORD_BITS-1:0]  in_p2_y,
  input  wire logic signed [COORD_BITS-1:0]  in_p3_x,
  input  wire logic signed [COORD_BITS-1:0]  in_p3_y,
  input  wire logic        [INDEX_BITS-1:0]  in_sample_index,
  input  wire logic                          in_last_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed      [COORD_BITS-1:0]  out_point_x,
  output logic signed      [COORD_BITS-1:0]  out_point_y,
  output logic                               out_t_clamped,
  output logic                               out_last_point
);

  localparam int WB = 3 * T_FRAC_BITS + 1;
  localparam logic [COORD_BITS-1:0] SIGN_MASK = COORD_BITS'(1) << (COORD_BITS - 1);

  logic [STEP_BITS-1:0]  t_step_r;
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] adv;
  bez_adv_t              adv_s;

  logic [COORD_BITS-1:0] pts_nxt [8];
  logic [COORD_BITS-1:0] pts_r   [PARAM_STAGES][8];
  logic [NUM_STAGES-1:0] last_r;
  logic [BLEND_STAGES-1:0] clamp_r;

  logic [WB-1:0] w0, w1, w2, w3;
  logic          clamped;
  logic [COORD_BITS-1:0] px, py;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_step_r <= STEP_RESET;
    end else if (cfg_we) begin
      t_step_r <= cfg_wdata;
    end
  end

  always_comb begin
    adv[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign adv_s = '{param: adv[PARAM_STAGES-1:0], blend: adv[NUM_STAGES-1:PARAM_STAGES]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // offset binary: flip the sign bit
  assign pts_nxt[0] = unsigned'(in_p0_x) ^ SIGN_MASK;
  assign pts_nxt[1] = unsigned'(in_p0_y) ^ SIGN_MASK;
  assign pts_nxt[2] = unsigned'(in_p1_x) ^ SIGN_MASK;
  assign pts_nxt[3] = unsigned'(in_p1_y) ^ SIGN_MASK;
  assign pts_nxt[4] = unsigned'(in_p2_x) ^ SIGN_MASK;
  assign pts_nxt[5] = unsigned'(in_p2_y) ^ SIGN_MASK;
  assign pts_nxt[6] = unsigned'(in_p3_x) ^ SIGN_MASK;
  assign pts_nxt[7] = unsigned'(in_p3_y) ^ SIGN_MASK;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pts_r[0]  <= pts_nxt;
      last_r[0] <= in_last_sample;
    end
    for (int k = 1; k < PARAM_STAGES; k++) begin
      if (adv[k]) begin
        pts_r[k] <= pts_r[k-1];
      end
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
    if (adv[PARAM_STAGES]) begin
      clamp_r[0] <= clamped;
    end
    for (int k = 1; k < BLEND_STAGES; k++) begin
      if (adv[PARAM_STAGES+k]) begin
        clamp_r[k] <= clamp_r[k-1];
      end
    end
  end

  bez_param_gen #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_param_gen (
    .clk    (clk),
    .adv    (adv_s),
    .step   (t_step_r),
    .index  (in_sample_index),
    .w0     (w0),
    .w1     (w1),
    .w2     (w2),
    .w3     (w3),
    .clamped(clamped)
  );

  bez_blend #(
    .COORD_BITS (COORD_BITS),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_blend_x (
    .clk  (clk),
    .adv  (adv_s),
    .a    (pts_r[PARAM_STAGES-1][0]),
    .b    (pts_r[PARAM_STAGES-1][2]),
    .c    (pts_r[PARAM_STAGES-1][4]),
    .d    (pts_r[PARAM_STAGES-1][6]),
    .w0   (w0),
    .w1   (w1),
    .w2   (w2),
    .w3   (w3),
    .point(px)
  );

  bez_blend #(
    .COORD_BITS (COORD_BITS),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_blend_y (
    .clk  (clk),
    .adv  (adv_s),
    .a    (pts_r[PARAM_STAGES-1][1]),
    .b    (pts_r[PARAM_STAGES-1][3]),
    .c    (pts_r[PARAM_STAGES-1][5]),
    .d    (pts_r[PARAM_STAGES-1][7]),
    .w0   (w0),
    .w1   (w1),
    .w2   (w2),
    .w3   (w3),
    .point(py)
  );

  assign in_stall       = !adv[0];
  assign out_valid      = v_r[NUM_STAGES-1];
  assign out_point_x    = signed'(px);
  assign out_point_y    = signed'(py);
  assign out_t_clamped  = clamp_r[BLEND_STAGES-1];
  assign out_last_point = last_r[NUM_STAGES-1];

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_r == '1) && out_stall)
    else $error("input stalled while the pipeline has a bubble");

  a_cfg_load: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> t_step_r == $past(cfg_wdata))
    else $error("step register missed a write");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> v_r == '0)
    else $error("stage valid bits not cleared by reset");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !v_r[NUM_STAGES-2] |=> !out_valid)
    else $error("result word repeated after delivery");

endmodule

`default_nettype wire
